// File: rtl/core/lgd_pkg.sv
// Shared types and constants of the fixed-point linear regression trainer.
`default_nettype none
package lgd_pkg;

  localparam int DEF_MAX_FEATURES = 32;
  localparam int DEF_LABEL_SHIFT  = 12;
  localparam int DEF_GRAD_SHIFT   = 8;

  localparam int FC_W   = 6;
  localparam int CNT_W  = 24;
  localparam int RATE_W = 24;
  localparam int CFG_W  = 24;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_FEATURE_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LEARN_RATE    = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET = 24'd65536;

  // Dividend of the update is (|grad| * rate) >> 16: 64 + 24 - 16 bits.
  localparam int DVD_W  = 72;
  localparam int QUOT_W = 41;
  localparam logic [QUOT_W:0] QCLAMP = 42'h100_0000_0000;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] feature;
    logic signed [15:0] label;
    logic               epoch_end;
  } item_t;

  typedef struct packed {
    logic [FC_W-1:0]   feature_count;
    logic [CNT_W-1:0]  sample_count;
    logic [RATE_W-1:0] learn_rate;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/core/lgd_front.sv
// Front end: accepts input beats into a two-entry queue ahead of the engine.
`default_nettype none
module lgd_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [lgd_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire                                 in_tuser,
  input  wire                                 in_tlast,
  output logic                                item_valid,
  output lgd_pkg::item_t                      item,
  input  wire                                 item_pop
);
  import lgd_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;
  item_t       new_item;

  assign in_tready  = (cnt_r != 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = slot_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign pop        = item_pop && item_valid;

  always_comb begin
    new_item.mode      = in_tuser;
    new_item.feature   = $signed(in_tdata[15:0]);
    new_item.label     = $signed(in_tdata[31:16]);
    new_item.epoch_end = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lgd_back.sv
// Back end: row accumulation, gradient walk, epoch update and weight report.
`default_nettype none
module lgd_back #(
  parameter int MAX_FEATURES = lgd_pkg::DEF_MAX_FEATURES,
  parameter int LABEL_SHIFT  = lgd_pkg::DEF_LABEL_SHIFT,
  parameter int GRAD_SHIFT   = lgd_pkg::DEF_GRAD_SHIFT
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  lgd_pkg::cfg_t                     cfg,
  input  wire                               item_valid,
  input  lgd_pkg::item_t                    item,
  output logic                              item_pop,
  output logic                              res_valid,
  input  wire                               res_ready,
  output logic [4:0]                        res_index,
  output logic signed [31:0]                res_weight,
  output logic                              res_last,
  output logic                              res_error
);
  import lgd_pkg::*;

  localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int NW = $clog2(MAX_FEATURES + 1);
  localparam logic [7:0] MAX8 = 8'(MAX_FEATURES);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_WA    = 4'd3;
  localparam logic [3:0] ST_WB    = 4'd4;
  localparam logic [3:0] ST_WC    = 4'd5;
  localparam logic [3:0] ST_USTART = 4'd6;
  localparam logic [3:0] ST_UM0   = 4'd7;
  localparam logic [3:0] ST_UM1   = 4'd8;
  localparam logic [3:0] ST_UM2   = 4'd9;
  localparam logic [3:0] ST_DIV   = 4'd10;
  localparam logic [3:0] ST_APPLY = 4'd11;
  localparam logic [3:0] ST_EMIT  = 4'd12;

  logic [3:0]               state_r;
  item_t                    cur_r;
  logic signed [31:0]       weights_r [MAX_FEATURES];
  logic [63:0]              grads_r   [MAX_FEATURES];
  logic signed [15:0]       rowbuf_r  [MAX_FEATURES];
  logic [63:0]              dot_r;
  logic [IW-1:0]            col_r;
  logic [IW-1:0]            k_r;
  logic signed [47:0]       prod_r;
  logic [63:0]              err_r;
  logic signed [48:0]       p0_r;
  logic [31:0]              p1_r;
  logic                     div_err_r;
  logic                     neg_r;
  logic [55:0]              pl_r, ph_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [CNT_W-1:0]         rem_r;
  logic [QUOT_W-1:0]        quot_r;
  logic [6:0]               bits_r;
  logic                     res_valid_r;
  logic [4:0]               res_index_r;
  logic signed [31:0]       res_weight_r;
  logic                     res_last_r;
  logic                     res_error_r;

  logic [7:0]               n8;
  logic [NW-1:0]            n;
  logic [NW-1:0]            col_inc;
  logic                     k_last;
  logic [IW-1:0]            w_idx;
  logic signed [31:0]       w_sel;
  logic signed [15:0]       rb_sel;
  logic [63:0]              g_sel;
  logic [63:0]              mag;
  logic [63:0]              dot_new;
  logic signed [63:0]       label_ext;
  logic signed [32:0]       err_lo, err_hi;
  logic signed [48:0]       p0_nxt, p1_full;
  logic signed [63:0]       wsum;
  logic signed [63:0]       gdelta;
  logic [CNT_W-1:0]         dsr;
  logic [87:0]              prod88;
  logic [CNT_W:0]           rem2;
  logic                     qbit;
  logic [QUOT_W:0]          q2;
  logic signed [42:0]       w_new;
  logic signed [31:0]       w_sat;

  always_comb begin
    if (cfg.feature_count == '0)        n8 = 8'd1;
    else if ({2'b0, cfg.feature_count} > MAX8) n8 = MAX8;
    else                                n8 = {2'b0, cfg.feature_count};
    n = n8[NW-1:0];
  end

  assign col_inc = NW'(col_r) + NW'(1);
  assign k_last  = (NW'(k_r) == n - NW'(1));
  assign w_idx   = (state_r == ST_MUL) ? col_r : k_r;
  assign w_sel   = weights_r[w_idx];
  assign rb_sel  = rowbuf_r[k_r];
  assign g_sel   = grads_r[k_r];
  assign mag     = g_sel[63] ? (64'd0 - g_sel) : g_sel;
  assign dot_new = dot_r + 64'(prod_r);
  assign label_ext = 64'(cur_r.label) <<< LABEL_SHIFT;
  assign err_lo  = $signed({1'b0, err_r[31:0]});
  assign err_hi  = $signed({1'b0, err_r[63:32]});
  assign p0_nxt  = rb_sel * err_lo;
  assign p1_full = rb_sel * err_hi;
  assign wsum    = 64'(p0_r) + $signed({p1_r, 32'd0});
  assign gdelta  = wsum >>> GRAD_SHIFT;
  assign dsr     = cfg.sample_count >> GRAD_SHIFT;
  assign prod88  = {ph_r, 32'd0} + {32'd0, pl_r};

  // One restoring division step per cycle; the quotient saturates at 2^40.
  always_comb begin
    rem2 = {rem_r, dvd_r[DVD_W-1]};
    qbit = (rem2 >= {1'b0, dsr});
    q2   = {quot_r, qbit};
    if (q2 > QCLAMP) q2 = QCLAMP;
  end

  always_comb begin
    if (neg_r) w_new = 43'(w_sel) + $signed({2'b0, quot_r});
    else       w_new = 43'(w_sel) - $signed({2'b0, quot_r});
    if (w_new > 43'sd2147483647)       w_sat = 32'sh7fffffff;
    else if (w_new < -43'sd2147483648) w_sat = 32'sh80000000;
    else                               w_sat = w_new[31:0];
  end

  assign item_pop   = (state_r == ST_IDLE);
  assign res_valid  = res_valid_r;
  assign res_index  = res_index_r;
  assign res_weight = res_weight_r;
  assign res_last   = res_last_r;
  assign res_error  = res_error_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL: begin
        rowbuf_r[col_r] <= cur_r.feature;
        prod_r          <= cur_r.feature * w_sel;
      end
      ST_WA: p0_r <= p0_nxt;
      ST_WB: p1_r <= p1_full[31:0];
      ST_UM0: begin
        neg_r <= g_sel[63];
        pl_r  <= mag[31:0] * cfg.learn_rate;
      end
      ST_UM1: ph_r <= mag[63:32] * cfg.learn_rate;
      default: ;
    endcase
    if (state_r == ST_IDLE && item_valid) cur_r <= item;
    if (state_r == ST_ACC) err_r <= label_ext - dot_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dot_r       <= '0;
      col_r       <= '0;
      k_r         <= '0;
      div_err_r   <= 1'b0;
      res_valid_r <= 1'b0;
      dvd_r       <= '0;
      rem_r       <= '0;
      quot_r      <= '0;
      bits_r      <= '0;
      for (int i = 0; i < MAX_FEATURES; i++) begin
        weights_r[i] <= 32'sd1;
        grads_r[i]   <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.mode) begin
              for (int i = 0; i < MAX_FEATURES; i++) begin
                weights_r[i] <= 32'sd1;
                grads_r[i]   <= '0;
              end
              dot_r <= '0;
              col_r <= '0;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          if (col_inc >= n) begin
            dot_r   <= '0;
            col_r   <= '0;
            k_r     <= '0;
            state_r <= ST_WA;
          end else begin
            dot_r   <= dot_new;
            col_r   <= col_r + IW'(1);
            state_r <= cur_r.epoch_end ? ST_USTART : ST_IDLE;
          end
        end
        ST_WA: state_r <= ST_WB;
        ST_WB: state_r <= ST_WC;
        ST_WC: begin
          grads_r[k_r] <= g_sel - gdelta;
          if (k_last) begin
            state_r <= cur_r.epoch_end ? ST_USTART : ST_IDLE;
          end else begin
            k_r     <= k_r + IW'(1);
            state_r <= ST_WA;
          end
        end
        ST_USTART: begin
          // A partial row is dropped before the update.
          dot_r     <= '0;
          col_r     <= '0;
          k_r       <= '0;
          div_err_r <= (dsr == '0);
          state_r   <= ST_UM0;
        end
        ST_UM0: begin
          if (div_err_r) begin
            res_valid_r  <= 1'b1;
            res_index_r  <= 5'(k_r);
            res_weight_r <= w_sel;
            res_last_r   <= k_last;
            res_error_r  <= 1'b1;
            state_r      <= ST_EMIT;
          end else begin
            state_r <= ST_UM1;
          end
        end
        ST_UM1: state_r <= ST_UM2;
        ST_UM2: begin
          dvd_r   <= prod88[87:16];
          rem_r   <= '0;
          quot_r  <= '0;
          bits_r  <= 7'(DVD_W);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= qbit ? CNT_W'(rem2 - {1'b0, dsr}) : rem2[CNT_W-1:0];
          quot_r <= q2[QUOT_W-1:0];
          dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
          bits_r <= bits_r - 7'd1;
          if (bits_r == 7'd1) state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          weights_r[k_r] <= w_sat;
          res_valid_r    <= 1'b1;
          res_index_r    <= 5'(k_r);
          res_weight_r   <= w_sat;
          res_last_r     <= k_last;
          res_error_r    <= 1'b0;
          state_r        <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready) begin
            res_valid_r <= 1'b0;
            if (res_last_r) begin
              for (int i = 0; i < MAX_FEATURES; i++) grads_r[i] <= '0;
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + IW'(1);
              state_r <= ST_UM0;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/linreg_gradient_descent_fixed_core.sv
// Top level of the fixed-point linear regression trainer.
// Feature beats carry feature and label in tdata, restart in tuser and the
// epoch end in tlast; a two-entry queue decouples the input from the engine.
// A feature beat passes through the pop, multiply and accumulate steps of the
// engine; the beat that ends a row adds a gradient walk over each active column
// through the two 16x33 multipliers that form the low and high halves.
// An epoch end starts the update and then reports one weight per active column;
// each weight goes through multiply setup, the bit-serial divider, an apply
// step and the output handshake, or, if the sample count shifted by GRAD_SHIFT
// is zero, is reported unchanged with the divide error flag.
// A restart beat produces no output.
`default_nettype none
module linreg_gradient_descent_fixed_core #(
  parameter int MAX_FEATURES = lgd_pkg::DEF_MAX_FEATURES,
  parameter int LABEL_SHIFT  = lgd_pkg::DEF_LABEL_SHIFT,
  parameter int GRAD_SHIFT   = lgd_pkg::DEF_GRAD_SHIFT
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire  [lgd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire  [lgd_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [lgd_pkg::IN_DATA_W-1:0]       in_tdata,   // feature, label
  input  wire                                 in_tuser,   // mode
  input  wire                                 in_tlast,   // epoch_end
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [lgd_pkg::OUT_DATA_W-1:0]      out_tdata,  // weight_index, weight_value
  output logic                                out_tuser,  // divide_error
  output logic                                out_tlast   // last_weight
);
  import lgd_pkg::*;

  cfg_t                cfg_r;
  item_t               item;
  logic                item_valid;
  logic                item_pop;
  logic [4:0]          res_index;
  logic signed [31:0]  res_weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.feature_count <= FC_W'(1);
      cfg_r.sample_count  <= CNT_W'(1);
      cfg_r.learn_rate    <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FEATURE_COUNT: cfg_r.feature_count <= cfg_wdata[FC_W-1:0];
        REG_SAMPLE_COUNT:  cfg_r.sample_count  <= cfg_wdata[CNT_W-1:0];
        REG_LEARN_RATE:    cfg_r.learn_rate    <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  lgd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  lgd_back #(
    .MAX_FEATURES (MAX_FEATURES),
    .LABEL_SHIFT  (LABEL_SHIFT),
    .GRAD_SHIFT   (GRAD_SHIFT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_index  (res_index),
    .res_weight (res_weight),
    .res_last   (out_tlast),
    .res_error  (out_tuser)
  );

  assign out_tdata = {3'b000, res_weight, res_index};

endmodule
`default_nettype wire

// File: tb/tb_linreg_gradient_descent_fixed_core.sv
// Self-checking testbench of the fixed-point linear regression trainer core.
`timescale 1ns / 100ps
module tb_linreg_gradient_descent_fixed_core;
  import lgd_pkg::*;

  localparam int NF = DEF_MAX_FEATURES;
  localparam int LABEL_SHIFT_C = DEF_LABEL_SHIFT;
  localparam int GRAD_SHIFT_C = DEF_GRAD_SHIFT;

  typedef struct {
    logic [4:0]  index;
    logic [31:0] value;
    logic        last;
    logic        div_err;
  } weight_rep_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  linreg_gradient_descent_fixed_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // Trainer mirror: configuration and learning state.
  logic [FC_W-1:0]   m_count = 6'd1;
  logic [CNT_W-1:0]  m_samples = 24'd1;
  logic [RATE_W-1:0] m_rate = RATE_RESET;
  int                m_weight[NF];
  longint            m_grad[NF];
  logic signed [15:0] m_row[NF];
  longint            m_dot;
  int                m_col;

  weight_rep_t weight_q[$];
  int mismatches = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  function automatic int active_columns();
    if (m_count == 0) return 1;
    if (m_count > NF) return NF;
    return int'(m_count);
  endfunction

  function automatic void clear_learning();
    for (int k = 0; k < NF; k++) m_grad[k] = 0;
    m_dot = 0;
    m_col = 0;
  endfunction

  // Applies one accepted beat to the mirror and queues the weights it reports.
  function automatic void train_step(bit mode, logic signed [15:0] feat,
                                     logic signed [15:0] lab, bit ep_end);
    int n;
    longint err;
    logic [63:0] dvs, mag;
    logic [127:0] prod, quot;
    longint q, w;
    bit neg, zero_div;
    weight_rep_t r;
    n = active_columns();
    if (mode) begin
      for (int k = 0; k < NF; k++) m_weight[k] = 1;
      clear_learning();
      return;
    end
    if (m_col < NF) begin
      m_row[m_col] = feat;
      m_dot += longint'(feat) * longint'(m_weight[m_col]);
    end
    m_col++;
    if (m_col >= n) begin
      err = (longint'(lab) <<< LABEL_SHIFT_C) - m_dot;
      for (int k = 0; k < n; k++) m_grad[k] -= (longint'(m_row[k]) * err) >>> GRAD_SHIFT_C;
      m_dot = 0;
      m_col = 0;
    end
    if (!ep_end) return;
    m_dot = 0;
    m_col = 0;
    dvs = {40'd0, m_samples >> GRAD_SHIFT_C} << 16;
    zero_div = (dvs == 0);
    for (int k = 0; k < n; k++) begin
      if (!zero_div) begin
        neg = m_grad[k] < 0;
        mag = neg ? -m_grad[k] : m_grad[k];
        prod = {64'd0, mag} * {104'd0, m_rate};
        quot = prod / {64'd0, dvs};
        q = (quot > (128'd1 << 40)) ? (longint'(1) << 40) : longint'(quot[63:0]);
        w = longint'(m_weight[k]) - (neg ? -q : q);
        if (w > 64'sd2147483647) w = 64'sd2147483647;
        if (w < -64'sd2147483648) w = -64'sd2147483648;
        m_weight[k] = int'(w);
      end
      r.index = k[4:0];
      r.value = m_weight[k];
      r.last = (k == n - 1);
      r.div_err = zero_div;
      weight_q.push_back(r);
    end
    for (int k = 0; k < NF; k++) m_grad[k] = 0;
  endfunction

  // Sends one beat; the sender may idle between bursts of random length.
  task automatic send_beat(bit mode, logic signed [15:0] feat,
                           logic signed [15:0] lab, bit ep_end);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {lab, feat};
    in_tlast <= ep_end;
    do @(posedge clk); while (!in_tready);
    train_step(mode, feat, lab, ep_end);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Register writes happen only with the core drained and quiet.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
    idle_input();
    wait (weight_q.size() == 0);
    repeat (400) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_FEATURE_COUNT: m_count = data[FC_W-1:0];
      REG_SAMPLE_COUNT:  m_samples = data[CNT_W-1:0];
      REG_LEARN_RATE:    m_rate = data[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int cnt, int samples, int rate);
    write_reg(REG_FEATURE_COUNT, CFG_W'(cnt));
    write_reg(REG_SAMPLE_COUNT, CFG_W'(samples));
    write_reg(REG_LEARN_RATE, CFG_W'(rate));
  endtask

  task automatic send_row(int n, bit ep_end);
    logic signed [15:0] lab;
    lab = 16'($urandom);
    for (int c = 0; c < n; c++)
      send_beat(1'b0, 16'($urandom), lab, ep_end && (c == n - 1));
  endtask

  task automatic test_extremes();
    set_config(3, 256, 65536);
    send_beat(1'b0, -16'sd32768, 16'sd0, 1'b0);
    send_beat(1'b0, 16'sd32767, 16'sd0, 1'b0);
    send_beat(1'b0, 16'sd0, -16'sd32768, 1'b0);
    send_beat(1'b0, 16'sd32767, 16'sd0, 1'b0);
    send_beat(1'b0, -16'sd1, 16'sd5, 1'b0);
    send_beat(1'b0, 16'sd1, 16'sd32767, 1'b1);
  endtask

  task automatic test_divide_error();
    set_config(2, 255, 16777215);
    send_row(2, 1'b1);
    write_reg(REG_SAMPLE_COUNT, 24'd16777215);
    send_row(2, 1'b0);
    send_row(2, 1'b1);
  endtask

  // Restart ignores its epoch end flag and reports nothing.
  task automatic test_restart();
    send_beat(1'b0, 16'sd100, 16'sd7, 1'b0);
    send_beat(1'b1, 16'sd0, 16'sd0, 1'b1);
    send_row(2, 1'b1);
  endtask

  // The epoch ends inside a row, which is then discarded.
  task automatic test_partial_row();
    write_reg(REG_FEATURE_COUNT, 24'd4);
    send_row(4, 1'b0);
    send_beat(1'b0, 16'sd1234, -16'sd99, 1'b0);
    send_beat(1'b0, -16'sd4321, 16'sd77, 1'b1);
  endtask

  task automatic test_count_limits();
    set_config(0, 256, 0);
    send_beat(1'b0, 16'sd300, 16'sd3, 1'b1);
    write_reg(REG_FEATURE_COUNT, 24'd40);
    write_reg(REG_LEARN_RATE, 24'd1);
    send_row(NF, 1'b1);
  endtask

  // Lowering the count mid-row ends the row on the next beat.
  task automatic test_count_lowered();
    write_reg(REG_FEATURE_COUNT, 24'd5);
    send_row(5, 1'b0);
    send_beat(1'b0, 16'sd11, 16'sd1, 1'b0);
    send_beat(1'b0, 16'sd22, 16'sd2, 1'b0);
    send_beat(1'b0, 16'sd33, 16'sd3, 1'b0);
    write_reg(REG_FEATURE_COUNT, 24'd3);
    send_beat(1'b0, 16'sd44, 16'sd4, 1'b1);
  endtask

  task automatic test_random(int n_items);
    int sent, n, rows, pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? 8 : $urandom_range(1, 4);
      set_config(n, (pick == 1) ? $urandom_range(1, 255) : $urandom_range(256, 16777215),
                 (pick == 2) ? 16777215 : $urandom_range(0, 131072));
      rows = $urandom_range(1, 3);
      for (int r = 0; r < rows; r++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_beat(1'b1, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
          sent++;
        end else if (pick == 1) begin
          send_beat(1'b0, 16'($urandom), 16'($urandom), 1'b1);
          sent++;
        end
        send_row(n, r == rows - 1);
        sent += n;
      end
    end
  endtask

  // The receiver holds off while epochs pile up behind the input.
  task automatic test_backpressure();
    set_config(4, 300, 40000);
    hold_req = 1'b1;
    for (int e = 0; e < 2; e++) begin
      send_row(4, 1'b0);
      send_row(4, 1'b1);
    end
  endtask

  // Receiver: stall pattern with ready stretches, plus one long hold.
  initial begin
    int mode, span;
    forever begin
      if (hold_req) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(5, 60);
        repeat (span) begin
          @(negedge clk);
          out_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
      end
    end
  end

  always @(posedge clk) begin
    weight_rep_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (weight_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected weight beat: idx %0d", out_tdata[4:0]);
      end else begin
        e = weight_q.pop_front();
        if (out_tdata[4:0] !== e.index || out_tdata[36:5] !== e.value ||
            out_tlast !== e.last || out_tuser !== e.div_err) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Weight mismatch: exp idx %0d val %0d last %0b err %0b, ",
                      "got idx %0d val %0d last %0b err %0b"},
                     e.index, $signed(e.value), e.last, e.div_err, out_tdata[4:0],
                     $signed(out_tdata[36:5]), out_tlast, out_tuser);
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < NF; k++) begin
      m_weight[k] = 1;
      m_row[k] = '0;
    end
    clear_learning();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    send_row(1, 1'b1);
    test_extremes();
    test_divide_error();
    test_restart();
    test_partial_row();
    test_count_limits();
    test_count_lowered();
    test_backpressure();
    test_random(30);
    idle_input();
    wait (weight_q.size() == 0);
    repeat (3000) @(negedge clk);
    if (mismatches == 0 && weight_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/core/lgd_pkg.sv
rtl/core/lgd_front.sv
rtl/core/lgd_back.sv
rtl/core/linreg_gradient_descent_fixed_core.sv
tb/tb_linreg_gradient_descent_fixed_core.sv
